// ===== src/mss_pkg.sv =====
package mss_pkg;

    localparam int TRACKS  = 8;
    localparam int STEPS   = 16;
    localparam int MAX_OUT = 24;
    localparam int PHASES  = 100;
    localparam int DEPTH   = TRACKS * STEPS;

    localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int SLOT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_OUT + 1);

    typedef logic [TRK_W-1:0]  trk_idx_t;
    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [6:0]        phase_t;
    typedef logic [2:0]        trk_field_t;

    localparam logic [2:0] FN_WRITE   = 3'd0;
    localparam logic [2:0] FN_READ    = 3'd1;
    localparam logic [2:0] FN_CLR_TRK = 3'd2;
    localparam logic [2:0] FN_CLR_ALL = 3'd3;
    localparam logic [2:0] FN_START   = 3'd4;
    localparam logic [2:0] FN_STOP    = 3'd5;
    localparam logic [2:0] FN_TICK    = 3'd6;

    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic [6:0] gate;
        logic [6:0] velocity;
        logic [6:0] note;
        logic       active;
    } step_t;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] track;
        logic [3:0] step_slot;
        logic       active;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [6:0] gate_len;
    } cmd_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] track_out;
        logic       note_on;
        logic [6:0] note_out;
        logic [6:0] velocity_out;
        logic       active_out;
        logic [6:0] gate_out;
        logic       last;
    } evt_t;

    typedef struct packed {
        logic      rd_en;
        logic      wr_en;
        logic      clr_trk;
        logic      clr_all;
        trk_idx_t  trk;
        slot_idx_t slot;
        step_t     wdata;
    } store_req_t;

    typedef struct packed {
        logic push;
        logic flush;
        evt_t evt;
    } emit_t;

endpackage

// ===== src/mss_store.sv =====
module mss_store (
    input  logic                clk,
    input  logic                rst_n,
    input  mss_pkg::store_req_t sreq,
    output mss_pkg::step_t      rdata
);

    mss_pkg::step_t                   mem [mss_pkg::DEPTH];
    mss_pkg::step_t                   rd_reg;
    logic [mss_pkg::STEPS-1:0]        vld_reg [mss_pkg::TRACKS];
    logic                             vld_q_reg;
    mss_pkg::addr_t                   addr;

    assign addr = mss_pkg::addr_t'(sreq.trk) * mss_pkg::addr_t'(mss_pkg::STEPS)
                + mss_pkg::addr_t'(sreq.slot);

    // valid bits stand in for the cleared pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mss_pkg::TRACKS; i++)
            begin
                vld_reg[i] <= '0;
            end
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (sreq.clr_all)
            begin
                for (int i = 0; i < mss_pkg::TRACKS; i++)
                begin
                    vld_reg[i] <= '0;
                end
            end
            else if (sreq.clr_trk)
            begin
                vld_reg[sreq.trk] <= '0;
            end
            else if (sreq.wr_en)
            begin
                vld_reg[sreq.trk][sreq.slot] <= 1'b1;
            end
            if (sreq.rd_en)
            begin
                vld_q_reg <= vld_reg[sreq.trk][sreq.slot];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sreq.wr_en)
        begin
            mem[addr] <= sreq.wdata;
        end
        if (sreq.rd_en)
        begin
            rd_reg <= mem[addr];
        end
    end

    assign rdata = vld_q_reg ? rd_reg : '0;

endmodule

// ===== src/mss_obuf.sv =====
module mss_obuf (
    input  logic            clk,
    input  logic            rst_n,
    input  mss_pkg::emit_t  emit,
    output logic            ready,
    output logic            pend,
    output logic            evt_valid,
    input  logic            evt_stall,
    output mss_pkg::evt_t   evt
);

    mss_pkg::evt_t pend_reg;
    mss_pkg::evt_t out_reg;
    mss_pkg::evt_t out_next;
    logic          pend_vld_reg;
    logic          pend_vld_next;
    logic          out_vld_reg;
    logic          out_vld_next;
    logic          out_load;
    logic          take;

    assign take  = out_vld_reg && !evt_stall;
    assign ready = !out_vld_reg || !evt_stall;

    // one beat is held back so that the final one can carry last
    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        out_vld_next  = take ? 1'b0 : out_vld_reg;
        out_load      = 1'b0;
        out_next      = pend_reg;
        out_next.last = 1'b0;
        if (emit.push)
        begin
            out_load      = pend_vld_reg;
            pend_vld_next = 1'b1;
        end
        else if (emit.flush)
        begin
            out_load      = pend_vld_reg;
            out_next.last = 1'b1;
            pend_vld_next = 1'b0;
        end
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.push)
        begin
            pend_reg <= emit.evt;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign pend      = pend_vld_reg;
    assign evt_valid = out_vld_reg;
    assign evt       = out_reg;

endmodule

// ===== src/mss_ctrl.sv =====
module mss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  mss_pkg::cmd_t       cmd,
    output mss_pkg::store_req_t sreq,
    input  mss_pkg::step_t      srdata,
    output mss_pkg::emit_t      emit,
    input  logic                ob_ready,
    input  logic                ob_pend
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RELA  = 7'b0000010,
        S_SBRD  = 7'b0000100,
        S_SBREL = 7'b0001000,
        S_SBON  = 7'b0010000,
        S_RDOUT = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    mss_pkg::trk_idx_t           t_reg, t_next;
    mss_pkg::cnt_t               cnt_reg, cnt_next;
    logic [mss_pkg::TRACKS-1:0]  held_reg, held_next;
    logic [6:0]                  held_note_reg [mss_pkg::TRACKS];
    logic                        note_we;
    mss_pkg::slot_idx_t          pos_reg, pos_next;
    mss_pkg::phase_t             phase_reg, phase_next;
    mss_pkg::phase_t             gate_end_reg, gate_end_next;
    mss_pkg::phase_t             maxg_reg, maxg_next;
    logic                        running_reg, running_next;
    logic                        after_rel_reg, after_rel_next;
    mss_pkg::trk_field_t         rd_trk_reg, rd_trk_next;
    logic                        rd_ok_reg, rd_ok_next;

    logic                        trk_ok;
    logic                        slot_ok;
    logic                        t_last;
    logic                        can_push;
    logic                        rel_go;
    mss_pkg::phase_t             gclamp;
    mss_pkg::phase_t             maxg_new;
    mss_pkg::evt_t               off_evt;
    mss_pkg::evt_t               on_evt;
    mss_pkg::evt_t               rd_evt;

    assign cmd_stall = (state_reg != S_IDLE);

    assign trk_ok   = int'(cmd.track) < mss_pkg::TRACKS;
    assign slot_ok  = int'(cmd.step_slot) < mss_pkg::STEPS;
    assign t_last   = (t_reg == mss_pkg::trk_idx_t'(mss_pkg::TRACKS - 1));
    assign can_push = (cnt_reg < mss_pkg::cnt_t'(mss_pkg::MAX_OUT));
    assign rel_go   = !held_reg[t_reg] || ob_ready;
    assign gclamp   = (srdata.gate > mss_pkg::phase_t'(mss_pkg::PHASES))
                    ? mss_pkg::phase_t'(mss_pkg::PHASES) : srdata.gate;
    assign maxg_new = (srdata.active && (gclamp > maxg_reg)) ? gclamp : maxg_reg;

    always_comb
    begin
        off_evt              = '0;
        off_evt.kind         = mss_pkg::KIND_NOTE;
        off_evt.track_out    = mss_pkg::trk_field_t'(t_reg);
        off_evt.note_out     = held_note_reg[t_reg];

        on_evt               = '0;
        on_evt.kind          = mss_pkg::KIND_NOTE;
        on_evt.track_out     = mss_pkg::trk_field_t'(t_reg);
        on_evt.note_on       = 1'b1;
        on_evt.note_out      = srdata.note;
        on_evt.velocity_out  = srdata.velocity;

        rd_evt               = '0;
        rd_evt.kind          = mss_pkg::KIND_READ;
        rd_evt.track_out     = rd_trk_reg;
        if (rd_ok_reg)
        begin
            rd_evt.note_out     = srdata.note;
            rd_evt.velocity_out = srdata.velocity;
            rd_evt.active_out   = srdata.active;
            rd_evt.gate_out     = srdata.gate;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        note_we        = 1'b0;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        gate_end_next  = gate_end_reg;
        maxg_next      = maxg_reg;
        running_next   = running_reg;
        after_rel_next = after_rel_reg;
        rd_trk_next    = rd_trk_reg;
        rd_ok_next     = rd_ok_reg;
        sreq           = '0;
        emit           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cnt_next = '0;
                    case (cmd.func)
                        mss_pkg::FN_WRITE:
                        begin
                            sreq.wr_en          = trk_ok && slot_ok;
                            sreq.trk            = mss_pkg::trk_idx_t'(cmd.track);
                            sreq.slot           = mss_pkg::slot_idx_t'(cmd.step_slot);
                            sreq.wdata.active   = cmd.active;
                            sreq.wdata.note     = cmd.note;
                            sreq.wdata.velocity = cmd.velocity;
                            sreq.wdata.gate     = cmd.gate_len;
                        end
                        mss_pkg::FN_READ:
                        begin
                            sreq.rd_en  = 1'b1;
                            sreq.trk    = mss_pkg::trk_idx_t'(cmd.track);
                            sreq.slot   = mss_pkg::slot_idx_t'(cmd.step_slot);
                            rd_trk_next = cmd.track;
                            rd_ok_next  = trk_ok && slot_ok;
                            state_next  = S_RDOUT;
                        end
                        mss_pkg::FN_CLR_TRK:
                        begin
                            sreq.clr_trk = trk_ok;
                            sreq.trk     = mss_pkg::trk_idx_t'(cmd.track);
                        end
                        mss_pkg::FN_CLR_ALL:
                        begin
                            sreq.clr_all = 1'b1;
                        end
                        mss_pkg::FN_START:
                        begin
                            if (!running_reg)
                            begin
                                running_next  = 1'b1;
                                pos_next      = '0;
                                phase_next    = '0;
                                gate_end_next = '0;
                            end
                        end
                        mss_pkg::FN_STOP:
                        begin
                            if (running_reg)
                            begin
                                running_next   = 1'b0;
                                gate_end_next  = '0;
                                t_next         = '0;
                                after_rel_next = 1'b0;
                                state_next     = S_RELA;
                            end
                        end
                        mss_pkg::FN_TICK:
                        begin
                            if (running_reg)
                            begin
                                if (phase_reg == mss_pkg::phase_t'(mss_pkg::PHASES - 1))
                                begin
                                    phase_next = '0;
                                    pos_next   = (pos_reg ==
                                                  mss_pkg::slot_idx_t'(mss_pkg::STEPS - 1))
                                               ? '0 : pos_reg + mss_pkg::slot_idx_t'(1);
                                end
                                else
                                begin
                                    phase_next = phase_reg + mss_pkg::phase_t'(1);
                                end
                                t_next = '0;
                                if (phase_reg == '0)
                                begin
                                    maxg_next = '0;
                                    if (gate_end_reg == mss_pkg::phase_t'(mss_pkg::PHASES))
                                    begin
                                        gate_end_next  = '0;
                                        after_rel_next = 1'b1;
                                        state_next     = S_RELA;
                                    end
                                    else
                                    begin
                                        state_next = S_SBRD;
                                    end
                                end
                                else if ((gate_end_reg != '0) && (phase_reg == gate_end_reg))
                                begin
                                    gate_end_next  = '0;
                                    after_rel_next = 1'b0;
                                    state_next     = S_RELA;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RELA:
            begin
                if (rel_go)
                begin
                    if (held_reg[t_reg])
                    begin
                        emit.push          = can_push;
                        emit.evt           = off_evt;
                        cnt_next           = can_push ? cnt_reg + mss_pkg::cnt_t'(1) : cnt_reg;
                        held_next[t_reg]   = 1'b0;
                    end
                    if (t_last)
                    begin
                        t_next     = '0;
                        state_next = after_rel_reg ? S_SBRD : S_FIN;
                    end
                    else
                    begin
                        t_next = t_reg + mss_pkg::trk_idx_t'(1);
                    end
                end
            end
            S_SBRD:
            begin
                sreq.rd_en = 1'b1;
                sreq.trk   = t_reg;
                sreq.slot  = pos_reg;
                state_next = S_SBREL;
            end
            S_SBREL:
            begin
                if (rel_go)
                begin
                    if (held_reg[t_reg])
                    begin
                        emit.push        = can_push;
                        emit.evt         = off_evt;
                        cnt_next         = can_push ? cnt_reg + mss_pkg::cnt_t'(1) : cnt_reg;
                        held_next[t_reg] = 1'b0;
                    end
                    state_next = S_SBON;
                end
            end
            S_SBON:
            begin
                if (!srdata.active || ob_ready)
                begin
                    if (srdata.active)
                    begin
                        emit.push        = can_push;
                        emit.evt         = on_evt;
                        cnt_next         = can_push ? cnt_reg + mss_pkg::cnt_t'(1) : cnt_reg;
                        held_next[t_reg] = 1'b1;
                        note_we          = 1'b1;
                    end
                    maxg_next = maxg_new;
                    if (t_last)
                    begin
                        gate_end_next = maxg_new;
                        t_next        = '0;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        t_next     = t_reg + mss_pkg::trk_idx_t'(1);
                        state_next = S_SBRD;
                    end
                end
            end
            S_RDOUT:
            begin
                if (ob_ready)
                begin
                    emit.push  = can_push;
                    emit.evt   = rd_evt;
                    cnt_next   = can_push ? cnt_reg + mss_pkg::cnt_t'(1) : cnt_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ob_pend)
                begin
                    state_next = S_IDLE;
                end
                else if (ob_ready)
                begin
                    emit.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            cnt_reg       <= '0;
            held_reg      <= '0;
            pos_reg       <= '0;
            phase_reg     <= '0;
            gate_end_reg  <= '0;
            maxg_reg      <= '0;
            running_reg   <= 1'b0;
            after_rel_reg <= 1'b0;
            rd_trk_reg    <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            cnt_reg       <= cnt_next;
            held_reg      <= held_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            gate_end_reg  <= gate_end_next;
            maxg_reg      <= maxg_next;
            running_reg   <= running_next;
            after_rel_reg <= after_rel_next;
            rd_trk_reg    <= rd_trk_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

    // held note numbers only matter while the matching held bit is set
    always_ff @(posedge clk)
    begin
        if (note_we)
        begin
            held_note_reg[t_reg] <= srdata.note;
        end
    end

endmodule

// ===== src/multitrack_step_sequencer.sv =====
// Multitrack step sequencer with a pattern memory of TRACKS x STEPS steps.
// cmd channel: one beat per command (write, read, clear track, clear all,
// start, stop, tick). evt channel: note on/off events and step read-backs;
// the final beat caused by a command carries last. Both channels move a
// beat at a rising edge where valid is high and stall is low.
// Commands are taken one at a time; cmd_stall stays high until all beats
// of the current command have been handed to the output stage.
// Per command: write, clear, start and ticks with no track walk finish in
// S_IDLE. A read emits its beat from S_RDOUT. Stop or a gate release walks
// all tracks in S_RELA, one track at a time. A step start walks all tracks
// through the pattern memory read port, per track in the states read,
// release and note on (S_SBRD, S_SBREL, S_SBON), after a walk in S_RELA
// when a full gate release comes first. Reads and walks end in S_FIN.
// Reset clears the pattern (per-step valid bits), held notes, the step
// position and phase, and stops the sequencer; no clearing pass is needed.
// A stalled receiver holds the output beat; one further beat waits inside.
module multitrack_step_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mss_pkg::cmd_t  cmd,
    output logic           evt_valid,
    input  logic           evt_stall,
    output mss_pkg::evt_t  evt
);

    mss_pkg::store_req_t sreq;
    mss_pkg::step_t      srdata;
    mss_pkg::emit_t      emit;
    logic                ob_ready;
    logic                ob_pend;

    mss_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .sreq  (sreq),
        .rdata (srdata)
    );

    mss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .sreq      (sreq),
        .srdata    (srdata),
        .emit      (emit),
        .ob_ready  (ob_ready),
        .ob_pend   (ob_pend)
    );

    mss_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .ready     (ob_ready),
        .pend      (ob_pend),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

`ifndef SYNTHESIS
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.push || emit.flush) |-> ob_ready)
        else $error("beat pushed with no room in output stage");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_stall |-> !ob_pend)
        else $error("command taken while a beat still waits for last");

    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.flush && ob_pend) |=> (evt_valid && evt.last))
        else $error("closing beat not marked last");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

class step_event_book;
    mss_pkg::step_t pattern [mss_pkg::DEPTH];
    bit             held [mss_pkg::TRACKS];
    logic [6:0]     held_note [mss_pkg::TRACKS];
    int unsigned    position;
    int unsigned    phase;
    int unsigned    gate_end;
    bit             running;
    mss_pkg::evt_t  batch [$];
    mss_pkg::evt_t  pending_events [$];
    int unsigned    mismatches;

    function new();
        foreach (pattern[i])
            pattern[i] = '0;
        foreach (held[t])
        begin
            held[t] = 1'b0;
            held_note[t] = '0;
        end
        position = 0;
        phase = 0;
        gate_end = 0;
        running = 1'b0;
        mismatches = 0;
    endfunction

    function void add(logic kind, int t, logic on, logic [6:0] note, logic [6:0] vel,
                      logic act, logic [6:0] gate);
        mss_pkg::evt_t e;
        if (batch.size() >= mss_pkg::MAX_OUT)
            return;
        e.kind = kind;
        e.track_out = mss_pkg::trk_field_t'(t);
        e.note_on = on;
        e.note_out = note;
        e.velocity_out = vel;
        e.active_out = act;
        e.gate_out = gate;
        e.last = 1'b0;
        batch.push_back(e);
    endfunction

    function void release_track(int t);
        if (held[t])
        begin
            add(mss_pkg::KIND_NOTE, t, 1'b0, held_note[t], 7'd0, 1'b0, 7'd0);
            held[t] = 1'b0;
        end
    endfunction

    function void release_all();
        for (int t = 0; t < mss_pkg::TRACKS; t++)
            release_track(t);
    endfunction

    function void begin_step();
        mss_pkg::step_t s;
        int unsigned    g;
        int unsigned    maxg;
        maxg = 0;
        for (int t = 0; t < mss_pkg::TRACKS; t++)
        begin
            s = pattern[t * mss_pkg::STEPS + position];
            release_track(t);
            if (s.active)
            begin
                add(mss_pkg::KIND_NOTE, t, 1'b1, s.note, s.velocity, 1'b0, 7'd0);
                held[t] = 1'b1;
                held_note[t] = s.note;
                g = (int'(s.gate) > mss_pkg::PHASES) ? mss_pkg::PHASES : int'(s.gate);
                if (g > maxg)
                    maxg = g;
            end
        end
        gate_end = maxg;
    endfunction

    function void tick();
        if (phase == 0)
        begin
            if (gate_end == mss_pkg::PHASES)
            begin
                release_all();
                gate_end = 0;
            end
            begin_step();
        end
        else if (gate_end != 0 && phase == gate_end)
        begin
            release_all();
            gate_end = 0;
        end
        phase++;
        if (phase >= mss_pkg::PHASES)
        begin
            phase = 0;
            position = (position + 1) % mss_pkg::STEPS;
        end
    endfunction

    function void take_command(mss_pkg::cmd_t c);
        mss_pkg::step_t s;
        mss_pkg::evt_t  e;
        int             idx;
        bit             in_range;
        batch.delete();
        in_range = (c.track < mss_pkg::TRACKS) && (c.step_slot < mss_pkg::STEPS);
        idx = int'(c.track) * mss_pkg::STEPS + int'(c.step_slot);
        case (c.func)
            mss_pkg::FN_WRITE:
                if (in_range)
                begin
                    s.active = c.active;
                    s.note = c.note;
                    s.velocity = c.velocity;
                    s.gate = c.gate_len;
                    pattern[idx] = s;
                end
            mss_pkg::FN_READ:
            begin
                s = in_range ? pattern[idx] : '0;
                add(mss_pkg::KIND_READ, int'(c.track), 1'b0, s.note, s.velocity, s.active,
                    s.gate);
            end
            mss_pkg::FN_CLR_TRK:
                if (c.track < mss_pkg::TRACKS)
                    for (int i = 0; i < mss_pkg::STEPS; i++)
                        pattern[int'(c.track) * mss_pkg::STEPS + i] = '0;
            mss_pkg::FN_CLR_ALL:
                foreach (pattern[i])
                    pattern[i] = '0;
            mss_pkg::FN_START:
                if (!running)
                begin
                    running = 1'b1;
                    position = 0;
                    phase = 0;
                    gate_end = 0;
                end
            mss_pkg::FN_STOP:
                if (running)
                begin
                    running = 1'b0;
                    release_all();
                    gate_end = 0;
                end
            mss_pkg::FN_TICK:
                if (running)
                    tick();
            default:
                ;
        endcase
        if (batch.size() > 0)
        begin
            e = batch.pop_back();
            e.last = 1'b1;
            batch.push_back(e);
        end
        foreach (batch[i])
            pending_events.push_back(batch[i]);
    endfunction

    function string fmt(mss_pkg::evt_t e);
        return $sformatf("kind=%0d trk=%0d on=%0d note=%0d vel=%0d act=%0d gate=%0d last=%0d",
                         e.kind, e.track_out, e.note_on, e.note_out, e.velocity_out,
                         e.active_out, e.gate_out, e.last);
    endfunction

    function void note_miss(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function void match_event(mss_pkg::evt_t got);
        mss_pkg::evt_t want;
        if (pending_events.size() == 0)
        begin
            note_miss($sformatf("unexpected beat: %s", fmt(got)));
            return;
        end
        want = pending_events.pop_front();
        if (got !== want)
            note_miss($sformatf("beat mismatch: expected %s, actual %s", fmt(want), fmt(got)));
    endfunction
endclass

module tb_top;
    localparam logic [2:0] FN_UNUSED = 3'd7;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_stall;
    mss_pkg::cmd_t  cmd;
    logic           evt_valid;
    logic           evt_stall;
    mss_pkg::evt_t  evt;
    int             idle_pct = 21;
    int             stall_pct = 21;
    int             evt_hold_left = 0;
    step_event_book book;

    multitrack_step_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic mss_pkg::cmd_t rand_cmd(logic [2:0] f);
        mss_pkg::cmd_t c;
        c = mss_pkg::cmd_t'($urandom);
        c.func = f;
        return c;
    endfunction

    function automatic mss_pkg::cmd_t sel_cmd(logic [2:0] f, logic [2:0] trk, logic [3:0] slot);
        mss_pkg::cmd_t c;
        c = rand_cmd(f);
        c.track = trk;
        c.step_slot = slot;
        return c;
    endfunction

    task automatic send_cmd(input mss_pkg::cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        book.take_command(c);
    endtask

    task automatic send_plain(input logic [2:0] f);
        send_cmd(rand_cmd(f));
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_plain(mss_pkg::FN_TICK);
    endtask

    task automatic write_step(input logic [2:0] trk, input logic [3:0] slot, input logic act,
                              input logic [6:0] note, input logic [6:0] vel,
                              input logic [6:0] gate);
        mss_pkg::cmd_t c;
        c = sel_cmd(mss_pkg::FN_WRITE, trk, slot);
        c.active = act;
        c.note = note;
        c.velocity = vel;
        c.gate_len = gate;
        send_cmd(c);
    endtask

    // receiver side, with one long hold-off on request
    initial
    begin
        evt_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (evt_hold_left > 0)
            begin
                evt_hold_left--;
                evt_stall <= 1'b1;
            end
            else
                evt_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && evt_valid && !evt_stall)
            book.match_event(evt);

    initial
    begin
        int            r;
        mss_pkg::cmd_t c;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        book = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_cmd(sel_cmd(mss_pkg::FN_READ, 3'd7, 4'd15));
        write_step(3'd0, 4'd0, 1'b1, 7'd127, 7'd127, 7'd127);
        write_step(3'd7, 4'd15, 1'b1, 7'd0, 7'd0, 7'd0);
        write_step(3'd3, 4'd0, 1'b1, 7'd60, 7'd100, 7'd50);
        write_step(3'd2, 4'd1, 1'b1, 7'd64, 7'd1, 7'd0);
        send_cmd(sel_cmd(mss_pkg::FN_READ, 3'd0, 4'd0));
        send_cmd(sel_cmd(mss_pkg::FN_READ, 3'd7, 4'd15));
        send_plain(FN_UNUSED);
        send_plain(mss_pkg::FN_TICK);
        send_plain(mss_pkg::FN_STOP);
        send_plain(mss_pkg::FN_START);
        send_plain(mss_pkg::FN_START);
        // full gate on step 0, zero gate held over step 1
        send_ticks(mss_pkg::PHASES + 1);
        send_ticks(5);
        send_plain(mss_pkg::FN_STOP);
        send_cmd(sel_cmd(mss_pkg::FN_CLR_TRK, 3'd0, 4'd0));
        send_cmd(sel_cmd(mss_pkg::FN_READ, 3'd0, 4'd0));
        send_plain(mss_pkg::FN_CLR_ALL);
        send_cmd(sel_cmd(mss_pkg::FN_READ, 3'd3, 4'd0));

        // every track busy on two steps, receiver held off while ticks keep coming
        for (int t = 0; t < mss_pkg::TRACKS; t++)
        begin
            write_step(3'(t), 4'd0, 1'b1, 7'($urandom_range(127)), 7'($urandom_range(127)),
                       7'(mss_pkg::PHASES));
            write_step(3'(t), 4'd1, 1'b1, 7'($urandom_range(127)), 7'($urandom_range(127)),
                       7'($urandom_range(100)));
        end
        send_plain(mss_pkg::FN_START);
        evt_hold_left = 300;
        send_ticks(5);

        for (int n = 0; n < 105; n++)
        begin
            if (n == 30)
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            if (n == 70)
            begin
                idle_pct = 21;
                stall_pct = 21;
            end
            r = $urandom_range(99);
            if (r < 25)
            begin
                c = rand_cmd(mss_pkg::FN_WRITE);
                c.active = ($urandom_range(3) != 0);
                if ($urandom_range(9) != 0)
                    c.gate_len = 7'($urandom_range(100));
                send_cmd(c);
            end
            else if (r < 35)
                send_plain(mss_pkg::FN_READ);
            else if (r < 38)
                send_plain(mss_pkg::FN_CLR_TRK);
            else if (r < 40)
                send_plain(mss_pkg::FN_CLR_ALL);
            else if (r < 46)
                send_plain(mss_pkg::FN_START);
            else if (r < 50)
                send_plain(mss_pkg::FN_STOP);
            else if (r < 52)
                send_plain(FN_UNUSED);
            else
                send_plain(mss_pkg::FN_TICK);
        end
        cmd_valid <= 1'b0;

        while (book.pending_events.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (book.mismatches == 0 && book.pending_events.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
